// ----- hw/rtl/jddm_pkg.sv -----
package jddm_pkg;

    typedef enum logic [1:0] {
        DIR_OFF = 2'd0,
        DIR_CW  = 2'd1,
        DIR_CCW = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        ZONE_LOW     = 2'd0,
        ZONE_NEUTRAL = 2'd1,
        ZONE_HIGH    = 2'd2
    } zone_t;

    localparam int unsigned READING_W = 7;
    localparam int unsigned DUTY_W    = 8;
    localparam int unsigned PROD_W    = 14;   // factor (<= 62) times duty
    localparam int unsigned RECIP_W   = 15;
    localparam int unsigned RECIP_SH  = 20;
    localparam int unsigned TDATA_W   = 24;   // 20 bits of fields, padded to bytes

    localparam logic [READING_W-1:0] LOW_TOP   = 7'd60;
    localparam logic [READING_W-1:0] HIGH_BASE = 7'd68;
    localparam logic [READING_W-1:0] LOW_SPAN  = 7'd62;

    // ceil(2^20/62) and ceil(2^20/59): exact floor division for products < 2^14
    localparam logic [RECIP_W-1:0] RECIP_LOW  = 15'd16913;
    localparam logic [RECIP_W-1:0] RECIP_HIGH = 15'd17773;

    localparam logic [DUTY_W-1:0] PWM_MAX_RESET = 8'd235;

endpackage

// ----- hw/rtl/joystick_differential_drive_mixer.sv -----
// Path: a request accepted on s_* passes four registers (readings, product,
// quotient, output) before its result shows on m_*. Throughput: one request per
// cycle unless m_tready stalls it; the two multiplier stages set the depth.
// Reset (aresetn low, synchronous): pipeline emptied, both readings cleared,
// pwm_max back to 235. Output payload registers are not reset.
module joystick_differential_drive_mixer (
    input  logic        aclk,
    input  logic        aresetn,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // pwm_max
    // command byte in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte
    // motor command out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // [1:0] right_dir, [9:2] right_duty,
                                       // [11:10] left_dir, [19:12] left_duty
);

    localparam int unsigned RW = jddm_pkg::READING_W;
    localparam int unsigned DW = jddm_pkg::DUTY_W;
    localparam int unsigned PW = jddm_pkg::PROD_W;
    localparam int unsigned QW = jddm_pkg::PROD_W + jddm_pkg::RECIP_W;

    logic [DW-1:0] pwm_max_reg;

    // stage A: stored readings
    logic          a_valid_reg;
    logic [RW-1:0] throttle_reg, steer_reg;
    // stage B: zone and product
    logic          b_valid_reg;
    jddm_pkg::zone_t tz_b_reg, sz_b_reg;
    logic [PW-1:0] tprod_reg, sprod_reg;
    // stage C: magnitudes
    logic          c_valid_reg;
    jddm_pkg::zone_t tz_c_reg, sz_c_reg;
    logic [DW-1:0] spd_reg, mag_reg;
    // stage D: output
    logic          m_valid_reg;
    jddm_pkg::dir_t rd_reg, ld_reg;
    logic [DW-1:0] rs_reg, ls_reg;

    logic en_a, en_b, en_c, en_d;

    assign en_d = !m_valid_reg || m_tready;
    assign en_c = !c_valid_reg || en_d;
    assign en_b = !b_valid_reg || en_c;
    assign en_a = !a_valid_reg || en_b;

    assign s_tready  = en_a;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_max_reg <= jddm_pkg::PWM_MAX_RESET;
        end else if (cfg_valid) begin
            pwm_max_reg <= cfg_data;
        end
    end

    // ---------------- stage A ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            throttle_reg <= '0;
            steer_reg    <= '0;
        end else if (en_a) begin
            a_valid_reg <= s_tvalid;
            if (s_tvalid) begin
                if (s_tdata[7]) begin
                    steer_reg <= s_tdata[RW-1:0];
                end else begin
                    throttle_reg <= s_tdata[RW-1:0];
                end
            end
        end
    end

    // ---------------- stage B ----------------
    jddm_pkg::zone_t tz_b_next, sz_b_next;
    logic [RW-1:0]   tfac, sfac;

    function automatic jddm_pkg::zone_t zone_of(input logic [6:0] r);
        if (r <= jddm_pkg::LOW_TOP) begin
            return jddm_pkg::ZONE_LOW;
        end else if (r < jddm_pkg::HIGH_BASE) begin
            return jddm_pkg::ZONE_NEUTRAL;
        end
        return jddm_pkg::ZONE_HIGH;
    endfunction

    function automatic logic [6:0] factor_of(input logic [6:0] r, input jddm_pkg::zone_t z);
        logic [6:0] f;
        unique case (z)
            jddm_pkg::ZONE_LOW:  f = jddm_pkg::LOW_SPAN - r;
            jddm_pkg::ZONE_HIGH: f = r - jddm_pkg::HIGH_BASE;
            default:             f = '0;
        endcase
        return f;
    endfunction

    always_comb begin
        tz_b_next = zone_of(throttle_reg);
        sz_b_next = zone_of(steer_reg);
        tfac      = factor_of(throttle_reg, tz_b_next);
        sfac      = factor_of(steer_reg, sz_b_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            tz_b_reg  <= tz_b_next;
            sz_b_reg  <= sz_b_next;
            tprod_reg <= PW'(tfac) * PW'(pwm_max_reg);
            sprod_reg <= PW'(sfac) * PW'(pwm_max_reg);
        end
    end

    // ---------------- stage C ----------------
    // divide by 62 or 59 through a reciprocal multiply
    logic [QW-1:0] tquot, squot;

    always_comb begin
        tquot = QW'(tprod_reg) * QW'((tz_b_reg == jddm_pkg::ZONE_LOW)
                                     ? jddm_pkg::RECIP_LOW : jddm_pkg::RECIP_HIGH);
        squot = QW'(sprod_reg) * QW'((sz_b_reg == jddm_pkg::ZONE_LOW)
                                     ? jddm_pkg::RECIP_LOW : jddm_pkg::RECIP_HIGH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en_c) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            tz_c_reg <= tz_b_reg;
            sz_c_reg <= sz_b_reg;
            spd_reg  <= tquot[jddm_pkg::RECIP_SH +: DW];
            mag_reg  <= squot[jddm_pkg::RECIP_SH +: DW];
        end
    end

    // ---------------- stage D: mixing ----------------
    jddm_pkg::dir_t rd_next, ld_next;
    logic [DW-1:0]  rs_next, ls_next;
    logic [DW:0]    boost;
    logic [DW-1:0]  boosted, cut;
    logic           turning;

    always_comb begin
        boost   = {1'b0, spd_reg} + {1'b0, mag_reg};
        boosted = (boost > {1'b0, pwm_max_reg}) ? pwm_max_reg : boost[DW-1:0];
        cut     = (spd_reg > mag_reg) ? (spd_reg - mag_reg) : '0;
        turning = (sz_c_reg != jddm_pkg::ZONE_NEUTRAL) && (mag_reg != '0);

        rd_next = jddm_pkg::DIR_OFF;
        ld_next = jddm_pkg::DIR_OFF;
        rs_next = '0;
        ls_next = '0;
        if (tz_c_reg == jddm_pkg::ZONE_NEUTRAL) begin
            // spin in place, or stop
            if (turning) begin
                rs_next = mag_reg;
                ls_next = mag_reg;
                if (sz_c_reg == jddm_pkg::ZONE_LOW) begin
                    rd_next = jddm_pkg::DIR_CCW;
                    ld_next = jddm_pkg::DIR_CW;
                end else begin
                    rd_next = jddm_pkg::DIR_CW;
                    ld_next = jddm_pkg::DIR_CCW;
                end
            end
        end else begin
            rd_next = (tz_c_reg == jddm_pkg::ZONE_LOW) ? jddm_pkg::DIR_CCW : jddm_pkg::DIR_CW;
            ld_next = rd_next;
            rs_next = spd_reg;
            ls_next = spd_reg;
            if (turning) begin
                if (sz_c_reg == jddm_pkg::ZONE_LOW) begin
                    rs_next = cut;
                    ls_next = boosted;
                end else begin
                    ls_next = cut;
                    rs_next = boosted;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_d) begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            rd_reg <= rd_next;
            ld_reg <= ld_next;
            rs_reg <= rs_next;
            ls_reg <= ls_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, ls_reg, ld_reg, rs_reg, rd_reg};

    // ---------------- assertions ----------------
    // an empty output slot never holds off the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty output");

    // a quotient moved forward shows up as a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && en_d) |=> m_tvalid)
        else $error("result lost between quotient and output stage");

    // a stopped motor pair carries zero duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && rd_reg == jddm_pkg::DIR_OFF) |->
        (ld_reg == jddm_pkg::DIR_OFF && rs_reg == '0 && ls_reg == '0))
        else $error("off direction with nonzero duty");

    // opposite directions only when spinning, which runs both sides equally
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && rd_reg != ld_reg) |-> (rs_reg == ls_reg))
        else $error("spin with unequal duties");

endmodule
